>>> sv/plt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package plt_pkg;

    localparam int MAX_POINTS_DEF = 16;
    localparam int MAP_SIZE_DEF   = 65536;

    // register indexes (paddr[2])
    localparam logic REG_LAST_POSITION = 1'b0;
    localparam logic REG_POINT_COUNT   = 1'b1;

    // request class decided by the front end
    typedef enum logic [1:0] {
        K_LOAD = 2'd0,   // write a control point
        K_ZERO = 2'd1,   // answer level 0 at once (ignored load, or fewer than two points)
        K_LOOK = 2'd2    // segment search and interpolation
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [3:0]  slot;
        logic [15:0] position;
        logic [15:0] level;
        logic [15:0] sample;     // already clamped to the last valid position
        logic        clamped;
    } t_req;

endpackage
`default_nettype wire

>>> sv/plt_front.sv
`timescale 1ns / 1ps
`default_nettype none
module plt_front #(
    parameter int MAX_POINTS = plt_pkg::MAX_POINTS_DEF,
    parameter int MAP_SIZE   = plt_pkg::MAP_SIZE_DEF,
    localparam int CW = $clog2(MAX_POINTS + 1)
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_stall,
    input  wire               i_mode,
    input  wire  [3:0]        i_point_slot,
    input  wire  [15:0]       i_point_position,
    input  wire  [15:0]       i_point_level,
    input  wire  [15:0]       i_sample,
    input  wire  [15:0]       i_last_position,
    input  wire  [CW-1:0]     i_point_count,
    output logic              o_push,
    output plt_pkg::t_req     o_req,
    input  wire               i_full
);

    localparam logic [15:0] LIM_MAX = 16'(MAP_SIZE - 1);

    logic          r_fv;
    plt_pkg::t_req r_req;
    plt_pkg::t_req n_req;
    logic          accept;
    logic [15:0]   lim;

    assign o_stall = r_fv && i_full;
    assign accept  = i_valid && !o_stall;
    assign o_push  = r_fv && !i_full;
    assign o_req   = r_req;

    assign lim = (i_last_position > LIM_MAX) ? LIM_MAX : i_last_position;

    always_comb begin
        n_req          = '0;
        n_req.slot     = i_point_slot;
        n_req.position = i_point_position;
        n_req.level    = i_point_level;
        if (!i_mode) begin
            n_req.kind = ({4'b0, i_point_slot} < 8'(MAX_POINTS)) ? plt_pkg::K_LOAD
                                                                : plt_pkg::K_ZERO;
        end else begin
            n_req.clamped = i_sample > lim;
            n_req.sample  = n_req.clamped ? lim : i_sample;
            n_req.kind    = (i_point_count < CW'(2)) ? plt_pkg::K_ZERO : plt_pkg::K_LOOK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else begin
            r_fv <= accept || (r_fv && i_full);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= n_req;
        end
    end

endmodule
`default_nettype wire

>>> sv/plt_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module plt_fifo (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  wire plt_pkg::t_req i_data,
    output logic              o_full,
    input  wire               i_pop,
    output logic              o_valid,
    output plt_pkg::t_req     o_data
);

    plt_pkg::t_req r_mem [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule
`default_nettype wire

>>> sv/plt_div.sv
`timescale 1ns / 1ps
`default_nettype none
// restoring divider, one quotient bit per cycle; quotient must fit 16 bits
module plt_div (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    input  wire  [31:0] i_num,
    input  wire  [15:0] i_den,
    output logic        o_done,
    output logic [15:0] o_quot
);

    logic        r_busy;
    logic        r_done;
    logic [3:0]  r_cnt;
    logic [15:0] r_rem;
    logic [15:0] r_q;
    logic [15:0] r_den;
    logic [16:0] trial;
    logic        ge;

    assign trial  = {r_rem, r_q[15]};
    assign ge     = trial >= {1'b0, r_den};
    assign o_done = r_done;
    assign o_quot = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 4'd15;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 4'd1;
                if (r_cnt == 4'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num[31:16];
            r_q   <= i_num[15:0];
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? 16'(trial - {1'b0, r_den}) : trial[15:0];
            r_q   <= {r_q[14:0], ge};
        end
    end

endmodule
`default_nettype wire

>>> sv/plt_back.sv
`timescale 1ns / 1ps
`default_nettype none
module plt_back #(
    parameter int MAX_POINTS = plt_pkg::MAX_POINTS_DEF,
    localparam int AW = $clog2(MAX_POINTS),
    localparam int CW = $clog2(MAX_POINTS + 1)
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire  [CW-1:0]     i_point_count,
    input  wire               i_valid,
    input  wire plt_pkg::t_req i_req,
    output logic              o_pop,
    output logic              o_valid,
    input  wire               i_stall,
    output logic [15:0]       o_level,
    output logic              o_clamped
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SEARCH = 6'b000010,
        S_MUL    = 6'b000100,
        S_DIVGO  = 6'b001000,
        S_DIV    = 6'b010000,
        S_OUT    = 6'b100000
    } t_state;

    t_state      r_state;
    t_state      n_state;

    logic [31:0] r_pts [MAX_POINTS];    // {position, level}
    logic [31:0] r_rd;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] r_ridx;
    logic        r_first;
    logic [15:0] r_s;
    logic [15:0] r_pp;
    logic [15:0] r_pl;
    logic [15:0] r_off;
    logic [15:0] r_w;
    logic [15:0] r_mag;
    logic        r_up;
    logic [31:0] r_prod;
    logic [15:0] r_lvl;
    logic        r_clmp;
    logic        r_ov;

    logic [15:0] cur_pos;
    logic [15:0] cur_lev;
    logic [AW-1:0] last_idx;
    logic        hit;
    logic        out_free;
    logic        div_done;
    logic [15:0] quot;
    logic [15:0] step;

    assign cur_pos  = r_rd[31:16];
    assign cur_lev  = r_rd[15:0];
    assign last_idx = AW'(i_point_count - CW'(1));
    assign hit      = (r_pp < r_s) && (r_s <= cur_pos);
    assign out_free = !r_ov || !i_stall;
    assign o_pop    = (r_state == S_IDLE) && i_valid;
    assign step     = (quot > r_mag) ? r_mag : quot;
    assign rd_addr  = (r_state == S_SEARCH) ? r_ridx + AW'(1) : '0;

    assign o_valid   = r_ov;

    plt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_DIVGO),
        .i_num   (r_prod + {17'b0, r_w[15:1]}),
        .i_den   (r_w),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = (i_req.kind == plt_pkg::K_LOOK) ? S_SEARCH : S_OUT;
                end
            end
            S_SEARCH: begin
                if (r_first) begin
                    if (r_s <= cur_pos) begin
                        n_state = S_OUT;
                    end
                end else if (hit) begin
                    n_state = S_MUL;
                end else if (r_ridx == last_idx) begin
                    n_state = S_OUT;
                end
            end
            S_MUL:   n_state = S_DIVGO;
            S_DIVGO: n_state = S_DIV;
            S_DIV: begin
                if (div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && out_free) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    // point table: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (o_pop && i_req.kind == plt_pkg::K_LOAD) begin
            r_pts[AW'(i_req.slot)] <= {i_req.position, i_req.level};
        end
        r_rd <= r_pts[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_ridx  <= '0;
                r_first <= 1'b1;
                r_s     <= i_req.sample;
                r_lvl   <= '0;
                r_clmp  <= i_req.clamped;
            end
            S_SEARCH: begin
                if (r_first && r_s <= cur_pos) begin
                    r_lvl <= cur_lev;
                end else if (!r_first && hit) begin
                    r_off <= r_s - r_pp;
                    r_w   <= cur_pos - r_pp;
                    r_up  <= cur_lev >= r_pl;
                    r_mag <= (cur_lev >= r_pl) ? cur_lev - r_pl : r_pl - cur_lev;
                end else if (!r_first && r_ridx == last_idx) begin
                    r_lvl <= cur_lev;
                end else begin
                    r_pp    <= cur_pos;
                    r_pl    <= cur_lev;
                    r_first <= 1'b0;
                    r_ridx  <= r_ridx + AW'(1);
                end
            end
            S_MUL: begin
                r_prod <= r_off * r_mag;
            end
            S_DIV: begin
                if (div_done) begin
                    r_lvl <= r_up ? r_pl + step : r_pl - step;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            o_level   <= r_lvl;
            o_clamped <= r_clmp;
        end
    end

endmodule
`default_nettype wire

>>> sv/piecewise_linear_transfer_curve_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Piecewise-linear transfer curve for one color channel. Load requests
// (mode 0) write a control point {position, level} into the table slot given;
// lookup requests (mode 1) return the curve level at the sample position,
// interpolated between neighboring points with round-to-nearest, held flat
// below the first and above the last point, and zero while fewer than two
// points are in use. Samples above last_position are clamped to it and the
// result is flagged. Every request yields exactly one result; loads return
// level 0. Points must be loaded in ascending position order before use, and
// registers must be written over the APB port while no request is in flight;
// the block itself does not enforce this. On its way to the output register
// a load, or a lookup answered with zero, passes the input register and the
// queue. A lookup that ends at the first point or past the last one also
// passes the segment search, which reads k table entries (1 to point_count),
// one per cycle from the point table. An interpolating lookup passes the
// input register, the queue, the segment search, the multiply, the divider
// start and the bit-serial divider (16 quotient bits, then a done strobe)
// before it loads the output register.
// Requests are processed one at a time in the back end; a two-entry queue
// and an input register let new requests in while the back end works, and
// the output register holds a result while the sink stalls.
module piecewise_linear_transfer_curve_top #(
    parameter int MAX_POINTS = plt_pkg::MAX_POINTS_DEF,
    parameter int MAP_SIZE   = plt_pkg::MAP_SIZE_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // input request channel
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire         i_mode,
    input  wire  [3:0]  i_point_slot,
    input  wire  [15:0] i_point_position,
    input  wire  [15:0] i_point_level,
    input  wire  [15:0] i_sample,
    // result channel
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [15:0] o_level,
    output logic        o_clamped,
    // register port
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW = $clog2(MAX_POINTS + 1);

    logic [15:0]   r_last_position;
    logic [4:0]    r_point_count;
    logic [CW-1:0] point_count;   // limited to MAX_POINTS

    logic          push;
    logic          full;
    logic          pop;
    logic          q_valid;
    plt_pkg::t_req front_req;
    plt_pkg::t_req q_req;

    assign pready = 1'b1;

    // register access
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_position <= 16'hFFFF;
            r_point_count   <= '0;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                plt_pkg::REG_LAST_POSITION: r_last_position <= pwdata[15:0];
                plt_pkg::REG_POINT_COUNT:   r_point_count   <= pwdata[4:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            plt_pkg::REG_LAST_POSITION: prdata = {16'b0, r_last_position};
            plt_pkg::REG_POINT_COUNT:   prdata = {27'b0, r_point_count};
            default:                    prdata = '0;
        endcase
    end

    assign point_count = ({3'b0, r_point_count} > 8'(MAX_POINTS)) ? CW'(MAX_POINTS)
                                                                  : CW'(r_point_count);

    // front end: accept, clamp sample, classify
    plt_front #(
        .MAX_POINTS (MAX_POINTS),
        .MAP_SIZE   (MAP_SIZE)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_in_valid),
        .o_stall          (o_in_stall),
        .i_mode           (i_mode),
        .i_point_slot     (i_point_slot),
        .i_point_position (i_point_position),
        .i_point_level    (i_point_level),
        .i_sample         (i_sample),
        .i_last_position  (r_last_position),
        .i_point_count    (point_count),
        .o_push           (push),
        .o_req            (front_req),
        .i_full           (full)
    );

    // decoupling queue
    plt_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_req),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_req)
    );

    // back end: point table, segment search, interpolation, output register
    plt_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_point_count (point_count),
        .i_valid       (q_valid),
        .i_req         (q_req),
        .o_pop         (pop),
        .o_valid       (o_out_valid),
        .i_stall       (i_out_stall),
        .o_level       (o_level),
        .o_clamped     (o_clamped)
    );

endmodule
`default_nettype wire
